>>> rtl/dfhc_pkg.sv
// ----------------------------------------------------------------------------
// dfhc_pkg
// shared types, codes and constants for the downlink frame header check unit
// ----------------------------------------------------------------------------
package dfhc_pkg;

   // widths fixed by the item fields
   localparam int FUNC_W    = 2;
   localparam int BYTE_W    = 8;
   localparam int STATUS_W  = 3;
   localparam int LEN_W     = 8;
   localparam int FOPTS_W   = 4;
   localparam int CNT_W     = 32;
   localparam int RCNT_W    = 16;
   localparam int SRC_W     = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 32;

   localparam int MAX_FRAME_BYTES_DEFAULT = 255;

   // smallest frame: header, address, control, counter, integrity code
   localparam logic [LEN_W-1:0] MIN_FRAME = LEN_W'(12);

   // function codes of an input beat
   localparam logic [FUNC_W-1:0] FUNC_BYTE    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_VERDICT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_UPLINK  = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_LENGTH   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_HEADER   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ADDRESS  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_COUNTER  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_PORT     = 3'd5;
   localparam logic [STATUS_W-1:0] ST_MIC_FAIL = 3'd6;
   localparam logic [STATUS_W-1:0] ST_NONE     = 3'd7;

   // message types accepted for downlink
   localparam logic [2:0] MTYPE_UNCONF = 3'd3;
   localparam logic [2:0] MTYPE_CONF   = 3'd5;

   // where mac commands live
   localparam logic [SRC_W-1:0] SRC_NONE    = 2'd0;
   localparam logic [SRC_W-1:0] SRC_OPTIONS = 2'd1;
   localparam logic [SRC_W-1:0] SRC_PORT0   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_ADDR = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CNT_PRESET = 1'd1;

   // captured header fields, frame length and overflow after the current byte
   typedef struct packed {
      logic [BYTE_W-1:0] header;
      logic [CNT_W-1:0]  address;
      logic [BYTE_W-1:0] control;
      logic [RCNT_W-1:0] rcnt;
      logic [BYTE_W-1:0] port;
      logic [LEN_W-1:0]  frame_len;
      logic              overflow;
   } cap_type;

   // configuration write
   typedef struct packed {
      logic                 wr;
      logic [CSR_IDX_W-1:0] index;
      logic [CSR_W-1:0]     data;
   } csr_wr_type;

   // one result beat
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   port_number;
      logic [LEN_W-1:0]    payload_length;
      logic [FOPTS_W-1:0]  options_length;
      logic [CNT_W-1:0]    candidate_counter;
      logic                ack_flag;
      logic [SRC_W-1:0]    command_source;
   } rsp_type;

endpackage

>>> rtl/dfhc_capture.sv
// ----------------------------------------------------------------------------
// dfhc_capture
// byte counter and header field capture for one received frame
// ----------------------------------------------------------------------------
module dfhc_capture #(
   parameter int MAX_FRAME_BYTES = dfhc_pkg::MAX_FRAME_BYTES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      take,
   input  logic                      clear,
   input  logic [dfhc_pkg::BYTE_W-1:0] frame_byte,
   output dfhc_pkg::cap_type         cap
);
   import dfhc_pkg::*;

   logic [LEN_W-1:0]  byte_index_ff, byte_index_in, idx_t;
   logic              overflow_ff, overflow_in, ovf_t;
   logic [BYTE_W-1:0] header_ff, header_in, header_t;
   logic [CNT_W-1:0]  address_ff, address_in, address_t;
   logic [BYTE_W-1:0] control_ff, control_in, control_t;
   logic [RCNT_W-1:0] rcnt_ff, rcnt_in, rcnt_t;
   logic [BYTE_W-1:0] port_ff, port_in, port_t;
   logic [LEN_W-1:0]  port_pos;

   assign port_pos = LEN_W'(8) + LEN_W'(control_ff[FOPTS_W-1:0]);

   always_comb begin
      idx_t     = byte_index_ff;
      ovf_t     = overflow_ff;
      header_t  = header_ff;
      address_t = address_ff;
      control_t = control_ff;
      rcnt_t    = rcnt_ff;
      port_t    = port_ff;
      if (take) begin
         if (byte_index_ff >= LEN_W'(MAX_FRAME_BYTES)) begin
            ovf_t = 1'b1;
         end else begin
            case (byte_index_ff)
               LEN_W'(0): header_t           = frame_byte;
               LEN_W'(1): address_t[7:0]     = frame_byte;
               LEN_W'(2): address_t[15:8]    = frame_byte;
               LEN_W'(3): address_t[23:16]   = frame_byte;
               LEN_W'(4): address_t[31:24]   = frame_byte;
               LEN_W'(5): control_t          = frame_byte;
               LEN_W'(6): rcnt_t             = RCNT_W'(frame_byte);
               LEN_W'(7): rcnt_t[15:8]       = frame_byte;
               default:   idx_t              = byte_index_ff;
            endcase
            // port byte sits right after the option bytes
            if (byte_index_ff == port_pos) begin
               port_t = frame_byte;
            end
            idx_t = byte_index_ff + LEN_W'(1);
         end
      end
   end

   always_comb begin
      if (clear) begin
         byte_index_in = '0;
         overflow_in   = 1'b0;
         header_in     = '0;
         address_in    = '0;
         control_in    = '0;
         rcnt_in       = '0;
         port_in       = '0;
      end else begin
         byte_index_in = idx_t;
         overflow_in   = ovf_t;
         header_in     = header_t;
         address_in    = address_t;
         control_in    = control_t;
         rcnt_in       = rcnt_t;
         port_in       = port_t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
         overflow_ff   <= 1'b0;
         header_ff     <= '0;
         address_ff    <= '0;
         control_ff    <= '0;
         rcnt_ff       <= '0;
         port_ff       <= '0;
      end else begin
         byte_index_ff <= byte_index_in;
         overflow_ff   <= overflow_in;
         header_ff     <= header_in;
         address_ff    <= address_in;
         control_ff    <= control_in;
         rcnt_ff       <= rcnt_in;
         port_ff       <= port_in;
      end
   end

   // a frame long enough for its options ends past all header fields and the port
   // byte, so the stored fields are final; length and overflow include this byte
   always_comb begin
      cap.header    = header_ff;
      cap.address   = address_ff;
      cap.control   = control_ff;
      cap.rcnt      = rcnt_ff;
      cap.port      = port_ff;
      cap.frame_len = idx_t;
      cap.overflow  = ovf_t;
   end

endmodule

>>> rtl/dfhc_session.sv
// ----------------------------------------------------------------------------
// dfhc_session
// frame checks, counter extension and session state (counter, pending, ack)
// ----------------------------------------------------------------------------
module dfhc_session (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  logic [dfhc_pkg::FUNC_W-1:0]  func,
   input  logic                         last_byte,
   input  logic                         mic_ok,
   input  dfhc_pkg::cap_type            cap,
   input  dfhc_pkg::csr_wr_type         csr,
   output logic                         res_valid,
   output dfhc_pkg::rsp_type            res
);
   import dfhc_pkg::*;

   logic [CNT_W-1:0] match_addr_ff, match_addr_in;
   logic [CNT_W-1:0] down_cnt_ff, down_cnt_in;
   logic [CNT_W-1:0] pend_cnt_ff, pend_cnt_in;
   logic             pend_valid_ff, pend_valid_in;
   logic             ack_ff, ack_in;

   logic               frame_end;
   logic [2:0]         mtype;
   logic [FOPTS_W-1:0] fopts;
   logic [LEN_W-1:0]   min_len, plen;
   logic               len_fail, hdr_fail, ack_set, addr_fail, len2_fail;
   logic               cnt_fail, port_fail, has_pay;
   logic [CNT_W-1:0]   cand;
   logic [BYTE_W-1:0]  port_v;
   logic [LEN_W-1:0]   pay_v;
   logic [SRC_W-1:0]   src_v;
   logic [STATUS_W-1:0] frame_status;

   assign frame_end = fire && (func == FUNC_BYTE) && last_byte;

   always_comb begin
      mtype    = cap.header[7:5];
      fopts    = cap.control[FOPTS_W-1:0];
      min_len  = MIN_FRAME + LEN_W'(fopts);
      len_fail = cap.overflow || (cap.frame_len < MIN_FRAME);
      hdr_fail = (cap.header[1:0] != 2'b00)
                 || ((mtype != MTYPE_UNCONF) && (mtype != MTYPE_CONF));
      ack_set  = !len_fail && !hdr_fail && (mtype == MTYPE_CONF);
      addr_fail = cap.address != match_addr_ff;
      len2_fail = cap.frame_len < min_len;

      // counter extension from the received low half
      cnt_fail = 1'b0;
      if (down_cnt_ff == '0) begin
         cand = CNT_W'(cap.rcnt);
      end else if (cap.rcnt == down_cnt_ff[RCNT_W-1:0]) begin
         cnt_fail = 1'b1;
         cand     = {down_cnt_ff[CNT_W-1:RCNT_W], cap.rcnt};
      end else if (cap.rcnt > down_cnt_ff[RCNT_W-1:0]) begin
         cand = {down_cnt_ff[CNT_W-1:RCNT_W], cap.rcnt};
      end else begin
         // rollover into the next upper half
         cand = {down_cnt_ff[CNT_W-1:RCNT_W] + RCNT_W'(1), cap.rcnt};
      end

      plen    = cap.frame_len - min_len;
      has_pay = plen != '0;
      port_v  = has_pay ? cap.port : '0;
      pay_v   = has_pay ? plen - LEN_W'(1) : '0;
      port_fail = has_pay && (fopts != '0) && (cap.port == '0);

      if (fopts != '0) begin
         src_v = SRC_OPTIONS;
      end else if ((pay_v != '0) && (port_v == '0)) begin
         src_v = SRC_PORT0;
      end else begin
         src_v = SRC_NONE;
      end

      if (len_fail) begin
         frame_status = ST_LENGTH;
      end else if (hdr_fail) begin
         frame_status = ST_HEADER;
      end else if (addr_fail) begin
         frame_status = ST_ADDRESS;
      end else if (len2_fail) begin
         frame_status = ST_LENGTH;
      end else if (cnt_fail) begin
         frame_status = ST_COUNTER;
      end else if (port_fail) begin
         frame_status = ST_PORT;
      end else begin
         frame_status = ST_OK;
      end
   end

   always_comb begin
      match_addr_in = match_addr_ff;
      down_cnt_in   = down_cnt_ff;
      pend_cnt_in   = pend_cnt_ff;
      pend_valid_in = pend_valid_ff;
      ack_in        = ack_ff;
      res_valid     = 1'b0;
      res           = '0;

      if (csr.wr) begin
         unique case (csr.index)
            CSR_MATCH_ADDR: match_addr_in = csr.data;
            CSR_CNT_PRESET: begin
               down_cnt_in   = csr.data;
               pend_valid_in = 1'b0;
            end
            default: match_addr_in = match_addr_ff;
         endcase
      end

      if (frame_end) begin
         res_valid  = 1'b1;
         ack_in     = ack_ff || ack_set;
         res.status = frame_status;
         res.ack_flag = ack_ff || ack_set;
         pend_valid_in = frame_status == ST_OK;
         if (frame_status == ST_OK) begin
            pend_cnt_in            = cand;
            res.port_number        = port_v;
            res.payload_length     = pay_v;
            res.options_length     = fopts;
            res.candidate_counter  = cand;
            res.command_source     = src_v;
         end
      end else if (fire && (func == FUNC_VERDICT)) begin
         res_valid    = 1'b1;
         res.ack_flag = ack_ff;
         if (!pend_valid_ff) begin
            res.status = ST_NONE;
         end else begin
            res.candidate_counter = pend_cnt_ff;
            pend_valid_in         = 1'b0;
            if (mic_ok) begin
               down_cnt_in = pend_cnt_ff;
               res.status  = ST_OK;
            end else begin
               res.status  = ST_MIC_FAIL;
            end
         end
      end else if (fire && (func == FUNC_UPLINK)) begin
         res_valid    = 1'b1;
         res.status   = ST_OK;
         res.ack_flag = ack_ff;
         ack_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_addr_ff <= '0;
         down_cnt_ff   <= '0;
         pend_cnt_ff   <= '0;
         pend_valid_ff <= 1'b0;
         ack_ff        <= 1'b0;
      end else begin
         match_addr_ff <= match_addr_in;
         down_cnt_ff   <= down_cnt_in;
         pend_cnt_ff   <= pend_cnt_in;
         pend_valid_ff <= pend_valid_in;
         ack_ff        <= ack_in;
      end
   end

endmodule

>>> rtl/downlink_frame_header_check_unit.sv
// ----------------------------------------------------------------------------
// downlink_frame_header_check_unit
// byte-wise downlink frame header check with 32-bit frame counter extension
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake              | beat
//   ---------+-----------+------------------------+-------------------------------
//   req_*    | in        | req_valid / req_stall  | func, frame byte, last, mic
//   rsp_*    | out       | rsp_valid / rsp_stall  | status and frame fields
//   csr_*    | in        | csr_valid / csr_ready  | register index and data
//
// one beat per cycle unless stalled: beat -> input register -> checks -> result register
// a request is held in the input register and its result in the result register
// results only come from the final frame byte, verdict and uplink beats
// csr_ready is low while a request sits in the input register
// reset (synchronous, active high) clears the session and the capture state
// a stalled result holds the pipe and raises req_stall once the input stage is full
//
module downlink_frame_header_check_unit #(
   parameter int MAX_FRAME_BYTES = dfhc_pkg::MAX_FRAME_BYTES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,

   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [dfhc_pkg::FUNC_W-1:0]        req_func,
   input  logic [dfhc_pkg::BYTE_W-1:0]        req_frame_byte,
   input  logic                               req_last_byte,
   input  logic                               req_mic_ok,

   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [dfhc_pkg::STATUS_W-1:0]      rsp_status,
   output logic [dfhc_pkg::BYTE_W-1:0]        rsp_port_number,
   output logic [dfhc_pkg::LEN_W-1:0]         rsp_payload_length,
   output logic [dfhc_pkg::FOPTS_W-1:0]       rsp_options_length,
   output logic [dfhc_pkg::CNT_W-1:0]         rsp_candidate_counter,
   output logic                               rsp_ack_flag,
   output logic [dfhc_pkg::SRC_W-1:0]         rsp_command_source,

   // configuration write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [dfhc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dfhc_pkg::CSR_W-1:0]         csr_data
);
   import dfhc_pkg::*;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [FUNC_W-1:0] in_func_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;
   logic              in_mic_ff;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;

   logic       advance, req_accept, fire, take, clear, res_valid;
   cap_type    cap;
   csr_wr_type csr;
   rsp_type    res;

   // pipe moves when the result register is empty or being taken
   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign fire       = in_valid_ff && advance;

   assign take  = fire && (in_func_ff == FUNC_BYTE);
   assign clear = take && in_last_ff;

   // registers are written only with the input stage empty
   assign csr_ready = !in_valid_ff;
   always_comb begin
      csr.wr    = csr_valid && csr_ready;
      csr.index = csr_index;
      csr.data  = csr_data;
   end

   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      rsp_valid_in = advance ? res_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_func_ff <= req_func;
         in_byte_ff <= req_frame_byte;
         in_last_ff <= req_last_byte;
         in_mic_ff  <= req_mic_ok;
      end
      if (advance && res_valid) begin
         rsp_ff <= res;
      end
   end

   dfhc_capture #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_capture (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .clear      (clear),
      .frame_byte (in_byte_ff),
      .cap        (cap)
   );

   dfhc_session u_session (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .func      (in_func_ff),
      .last_byte (in_last_ff),
      .mic_ok    (in_mic_ff),
      .cap       (cap),
      .csr       (csr),
      .res_valid (res_valid),
      .res       (res)
   );

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_ff.status;
   assign rsp_port_number       = rsp_ff.port_number;
   assign rsp_payload_length    = rsp_ff.payload_length;
   assign rsp_options_length    = rsp_ff.options_length;
   assign rsp_candidate_counter = rsp_ff.candidate_counter;
   assign rsp_ack_flag          = rsp_ff.ack_flag;
   assign rsp_command_source    = rsp_ff.command_source;

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the downlink frame header check unit: frames are
// streamed a byte per beat with verdict and uplink beats mixed in, every
// accepted beat runs through a model of the checks kept in a small
// scoreboard, and every result beat is compared field by field
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dfhc_pkg::*;

   localparam int MAX_BYTES     = dfhc_pkg::MAX_FRAME_BYTES_DEFAULT;
   localparam int SETTLE_CYCLES = 8;       // pipe is two deep, leave some margin
   localparam int HOLD_CYCLES   = 120;     // long receiver hold-off
   localparam int LIMIT_CYCLES  = 300000;
   localparam int N_PHASES      = 5;
   localparam int PHASE_BEATS   = 40;

   // the one function code the block ignores
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      STALL_OFF, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
   } stall_mode_type;

   // -------------------------------------------------------------------------
   // scoreboard: mirrors the header checks and counter extension, keeps the
   // reports still owed by the block
   // -------------------------------------------------------------------------
   class header_check_scoreboard_type;
      // session registers
      logic [CNT_W-1:0]  match_addr = '0;
      logic [CNT_W-1:0]  down_cnt = '0;
      // capture of the frame in flight
      int                frame_len = 0;
      logic              overflow = 1'b0;
      logic [7:0]        hdr = '0;
      logic [CNT_W-1:0]  addr_cap = '0;
      logic [7:0]        ctrl = '0;
      logic [RCNT_W-1:0] rcnt = '0;
      logic [7:0]        port_cap = '0;
      // candidate waiting for its integrity verdict, ack state
      logic [CNT_W-1:0]  held_cnt = '0;
      logic              held_valid = 1'b0;
      logic              ack_pending = 1'b0;
      rsp_type           reports_due[$];
      int                errors = 0;

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
         case (idx)
            CSR_MATCH_ADDR: match_addr = val;
            CSR_CNT_PRESET: begin
               down_cnt = val;
               held_valid = 1'b0;
            end
            default: ;
         endcase
      endfunction

      // one accepted request beat
      function void take_beat(logic [FUNC_W-1:0] func, logic [7:0] data, logic is_last,
                              logic mic);
         rsp_type          r;
         int               fopts;
         int               plen;
         int               pay;
         logic [2:0]       mtype;
         logic [7:0]       port;
         logic [CNT_W-1:0] cand;
         r = '0;
         if (func == FUNC_UNUSED)
            return;
         if (func == FUNC_BYTE) begin
            if (frame_len >= MAX_BYTES) begin
               overflow = 1'b1;
            end else begin
               if (frame_len == 0)
                  hdr = data;
               else if (frame_len <= 4)
                  addr_cap[8*(frame_len-1) +: 8] = data;
               else if (frame_len == 5)
                  ctrl = data;
               else if (frame_len == 6)
                  rcnt[7:0] = data;
               else if (frame_len == 7)
                  rcnt[15:8] = data;
               if (frame_len == 8 + int'(ctrl[3:0]))
                  port_cap = data;
               frame_len++;
            end
            if (!is_last)
               return;
            held_valid = 1'b0;
            fopts = int'(ctrl[3:0]);
            mtype = hdr[7:5];
            r.status = ST_OK;
            if (overflow || frame_len < int'(MIN_FRAME)) begin
               r.status = ST_LENGTH;
            end else if (hdr[1:0] != 2'd0
                         || (mtype != MTYPE_UNCONF && mtype != MTYPE_CONF)) begin
               r.status = ST_HEADER;
            end else begin
               if (mtype == MTYPE_CONF)
                  ack_pending = 1'b1;
               if (addr_cap != match_addr) begin
                  r.status = ST_ADDRESS;
               end else if (frame_len < int'(MIN_FRAME) + fopts) begin
                  r.status = ST_LENGTH;
               end else if (down_cnt != '0 && rcnt == down_cnt[15:0]) begin
                  r.status = ST_COUNTER;
               end else begin
                  // counter extension, rollover into the next upper half
                  if (down_cnt == '0)
                     cand = {16'h0, rcnt};
                  else if (rcnt > down_cnt[15:0])
                     cand = down_cnt + CNT_W'(rcnt) - CNT_W'(down_cnt[15:0]);
                  else
                     cand = {down_cnt[31:16] + 16'd1, rcnt};
                  plen = frame_len - (int'(MIN_FRAME) + fopts);
                  port = '0;
                  pay = 0;
                  if (plen > 0) begin
                     port = port_cap;
                     pay = plen - 1;
                  end
                  if (plen > 0 && fopts != 0 && port == 8'd0) begin
                     r.status = ST_PORT;
                  end else begin
                     r.port_number = port;
                     r.payload_length = LEN_W'(pay);
                     r.options_length = ctrl[3:0];
                     r.candidate_counter = cand;
                     if (fopts > 0)
                        r.command_source = SRC_OPTIONS;
                     else if (pay > 0 && port == 8'd0)
                        r.command_source = SRC_PORT0;
                     else
                        r.command_source = SRC_NONE;
                     held_cnt = cand;
                     held_valid = 1'b1;
                  end
               end
            end
            r.ack_flag = ack_pending;
            frame_len = 0;
            overflow = 1'b0;
            hdr = '0;
            addr_cap = '0;
            ctrl = '0;
            rcnt = '0;
            port_cap = '0;
         end else if (func == FUNC_VERDICT) begin
            if (!held_valid) begin
               r.status = ST_NONE;
            end else begin
               r.candidate_counter = held_cnt;
               if (mic) begin
                  down_cnt = held_cnt;
                  r.status = ST_OK;
               end else begin
                  r.status = ST_MIC_FAIL;
               end
               held_valid = 1'b0;
            end
            r.ack_flag = ack_pending;
         end else begin
            r.status = ST_OK;
            r.ack_flag = ack_pending;
            ack_pending = 1'b0;
         end
         reports_due.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
         if (want !== seen) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, seen);
            errors++;
         end
      endfunction

      // one accepted result beat
      function void check_report(rsp_type seen);
         rsp_type want;
         if (reports_due.size() == 0) begin
            $error("unexpected result beat, status %0d", seen.status);
            errors++;
            return;
         end
         want = reports_due.pop_front();
         compare_field("status", 32'(want.status), 32'(seen.status));
         compare_field("port_number", 32'(want.port_number), 32'(seen.port_number));
         compare_field("payload_length", 32'(want.payload_length), 32'(seen.payload_length));
         compare_field("options_length", 32'(want.options_length), 32'(seen.options_length));
         compare_field("candidate_counter", want.candidate_counter, seen.candidate_counter);
         compare_field("ack_flag", 32'(want.ack_flag), 32'(seen.ack_flag));
         compare_field("command_source", 32'(want.command_source), 32'(seen.command_source));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // clock, reset and block ports, every driven input known from time zero
   // -------------------------------------------------------------------------
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [FUNC_W-1:0]    req_func = '0;
   logic [BYTE_W-1:0]    req_frame_byte = '0;
   logic                 req_last_byte = 1'b0;
   logic                 req_mic_ok = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [BYTE_W-1:0]    rsp_port_number;
   logic [LEN_W-1:0]     rsp_payload_length;
   logic [FOPTS_W-1:0]   rsp_options_length;
   logic [CNT_W-1:0]     rsp_candidate_counter;
   logic                 rsp_ack_flag;
   logic [SRC_W-1:0]     rsp_command_source;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_data = '0;

   always #5 clock = ~clock;

   downlink_frame_header_check_unit uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_func              (req_func),
      .req_frame_byte        (req_frame_byte),
      .req_last_byte         (req_last_byte),
      .req_mic_ok            (req_mic_ok),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_port_number       (rsp_port_number),
      .rsp_payload_length    (rsp_payload_length),
      .rsp_options_length    (rsp_options_length),
      .rsp_candidate_counter (rsp_candidate_counter),
      .rsp_ack_flag          (rsp_ack_flag),
      .rsp_command_source    (rsp_command_source),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   header_check_scoreboard_type sb;

   // stimulus bookkeeping
   logic [7:0] frame_q[$];     // bytes of the frame about to be sent
   int         beats_sent = 0;
   int         burst_left = 0;
   bit         gaps_on = 1'b0;
   int         holds_asked = 0;
   int         cycle_count = 0;

   // -------------------------------------------------------------------------
   // monitors: sampled right at the edge, before any update of that edge
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (req_valid === 1'b1 && req_stall === 1'b0)
         sb.take_beat(req_func, req_frame_byte, req_last_byte, req_mic_ok);
   end

   always @(posedge clock) begin
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_report({rsp_status, rsp_port_number, rsp_payload_length, rsp_options_length,
                          rsp_candidate_counter, rsp_ack_flag, rsp_command_source});
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // receiver: stall modes that change at random, plus a long hold-off whenever
   // the stimulus asks for one
   // -------------------------------------------------------------------------
   stall_mode_type stall_mode = STALL_OFF;
   int             mode_left = 0;
   int             stall_phase = 0;
   int             hold_left = 0;
   int             holds_served = 0;

   always @(posedge clock) begin
      if (holds_served != holds_asked) begin
         holds_served <= holds_served + 1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= stall_mode_type'($urandom_range(0, 3));
            mode_left <= $urandom_range(16, 160);
         end else begin
            mode_left <= mode_left - 1;
         end
         stall_phase <= stall_phase + 1;
         case (stall_mode)
            STALL_OFF:   rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= ((stall_phase % 5) < 3);
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // driving tasks
   // -------------------------------------------------------------------------

   // one request beat; bursts of random length with random gaps when enabled
   task automatic send_beat(input logic [FUNC_W-1:0] f, input logic [7:0] b,
                            input logic is_last, input logic mic);
      int gap;
      if (gaps_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left--;
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_frame_byte <= b;
      req_last_byte <= is_last;
      req_mic_ok <= mic;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (f != FUNC_UNUSED)
         beats_sent++;
   endtask

   // verdict, uplink or ignored beat with random don't-care fields
   task automatic send_side_beat();
      logic [FUNC_W-1:0] f;
      case ($urandom_range(0, 4))
         0, 1:    f = FUNC_VERDICT;
         2, 3:    f = FUNC_UPLINK;
         default: f = FUNC_UNUSED;
      endcase
      send_beat(f, 8'($urandom), 1'($urandom), 1'($urandom));
   endtask

   // stream frame_q, sometimes with side beats slipped in mid-frame
   task automatic send_frame(input int mix_pct);
      int n;
      n = frame_q.size();
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < mix_pct)
            send_side_beat();
         send_beat(FUNC_BYTE, frame_q[i], logic'(i == n - 1), 1'($urandom));
      end
   endtask

   // mhdr, address (little endian), fctrl, fcnt, options, port, payload, mic
   function automatic void build_frame(logic [2:0] mtype, logic [1:0] major, logic [31:0] addr,
                                       logic [7:0] ctrl, logic [15:0] cnt, bit with_port,
                                       logic [7:0] port, int npay);
      frame_q.delete();
      frame_q.push_back({mtype, 3'($urandom), major});
      for (int i = 0; i < 4; i++)
         frame_q.push_back(addr[8*i +: 8]);
      frame_q.push_back(ctrl);
      frame_q.push_back(cnt[7:0]);
      frame_q.push_back(cnt[15:8]);
      repeat (int'(ctrl[3:0])) frame_q.push_back(8'($urandom));
      if (with_port) begin
         frame_q.push_back(port);
         repeat (npay) frame_q.push_back(8'($urandom));
      end
      repeat (4) frame_q.push_back(8'($urandom));
   endfunction

   // random frame aimed past the header checks, or broken in one chosen way
   task automatic send_random_frame(input bit flawed, input int mix_pct);
      logic [2:0]  mtype;
      logic [1:0]  major;
      logic [31:0] addr;
      logic [7:0]  ctrl;
      logic [7:0]  port;
      logic [15:0] cnt;
      bit          with_port;
      int          npay;
      int          pick;
      int          flaw;
      mtype = ($urandom_range(0, 2) == 0) ? MTYPE_CONF : MTYPE_UNCONF;
      major = 2'd0;
      addr = sb.match_addr;
      ctrl = 8'($urandom);
      if ($urandom_range(0, 2) != 0)
         ctrl[3:0] = 4'd0;
      else if ($urandom_range(0, 1) == 1)
         ctrl[3:0] = 4'($urandom_range(1, 3));
      with_port = 1'($urandom);
      port = 8'($urandom_range(1, 255));
      if (ctrl[3:0] == 4'd0 && $urandom_range(0, 5) == 0)
         port = 8'd0;
      npay = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 60) : $urandom_range(0, 8);
      // mostly a small step forward, sometimes a jump or a rollover
      pick = $urandom_range(0, 9);
      cnt = sb.down_cnt[15:0] + 16'($urandom_range(1, 40));
      if (pick == 0)
         cnt = 16'($urandom);
      else if (pick == 1)
         cnt = sb.down_cnt[15:0] - 16'($urandom_range(1, 40));
      flaw = flawed ? $urandom_range(0, 6) : -1;
      case (flaw)
         0: major = 2'($urandom_range(1, 3));
         1: begin
            do mtype = 3'($urandom); while (mtype == MTYPE_UNCONF || mtype == MTYPE_CONF);
         end
         2: addr = addr ^ (32'd1 << $urandom_range(0, 31));
         4: begin
            ctrl[3:0] = 4'($urandom_range(1, 15));
            with_port = 1'b0;
         end
         5: cnt = sb.down_cnt[15:0];
         6: begin
            ctrl[3:0] = 4'($urandom_range(1, 15));
            with_port = 1'b1;
            port = 8'd0;
         end
         default: ;
      endcase
      build_frame(mtype, major, addr, ctrl, cnt, with_port, port, npay);
      // frame too short overall, or too short for its options
      if (flaw == 3) begin
         pick = $urandom_range(1, 11);
         while (frame_q.size() > pick) void'(frame_q.pop_back());
      end else if (flaw == 4) begin
         repeat ($urandom_range(1, int'(ctrl[3:0]))) void'(frame_q.pop_back());
      end
      send_frame(mix_pct);
   endtask

   // release the request channel, wait out every owed result and the pipe
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.reports_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // both session registers, valid held high across the two writes
   task automatic write_session(input logic [31:0] addr, input logic [31:0] preset);
      csr_valid <= 1'b1;
      csr_index <= CSR_MATCH_ADDR;
      csr_data <= addr;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.write_reg(CSR_MATCH_ADDR, addr);
      csr_index <= CSR_CNT_PRESET;
      csr_data <= preset;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.write_reg(CSR_CNT_PRESET, preset);
      csr_valid <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // test sequence
   // -------------------------------------------------------------------------
   logic [31:0] phase_addr[N_PHASES];
   logic [31:0] phase_preset[N_PHASES];
   logic [31:0] sess_addr;
   int          target;
   int          sel;

   initial begin
      sb = new();
      sess_addr = 32'h2601_1bda;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      write_session(sess_addr, 32'h0);

      // ---- directed part, back to back ----
      // verdict with nothing waiting, uplink with no ack, ignored code
      send_beat(FUNC_VERDICT, 8'hff, 1'b1, 1'b1);
      send_beat(FUNC_UPLINK, 8'h00, 1'b0, 1'b0);
      send_beat(FUNC_UNUSED, 8'ha5, 1'b1, 1'b1);
      // smallest good frame, counter taken as is while the stored one is zero
      build_frame(MTYPE_UNCONF, 2'd0, sess_addr, 8'h00, 16'h0005, 1'b0, 8'h00, 0);
      send_frame(0);
      send_beat(FUNC_VERDICT, 8'h00, 1'b0, 1'b1);
      // same counter again is refused
      send_frame(0);
      // smaller counter rolls into the next upper half, then a failed verdict
      build_frame(MTYPE_UNCONF, 2'd0, sess_addr, 8'h00, 16'h0003, 1'b0, 8'h00, 0);
      send_frame(0);
      send_beat(FUNC_VERDICT, 8'h00, 1'b0, 1'b0);
      // confirmed frame with options and payload sets the ack
      build_frame(MTYPE_CONF, 2'd0, sess_addr, 8'h02, 16'h0009, 1'b1, 8'h07, 3);
      send_frame(0);
      send_beat(FUNC_VERDICT, 8'h00, 1'b0, 1'b1);
      send_beat(FUNC_UPLINK, 8'hff, 1'b1, 1'b1);
      send_beat(FUNC_UPLINK, 8'h00, 1'b0, 1'b0);
      // commands on port zero, and port zero together with options
      build_frame(MTYPE_UNCONF, 2'd0, sess_addr, 8'h00, 16'h000a, 1'b1, 8'h00, 4);
      send_frame(0);
      build_frame(MTYPE_UNCONF, 2'd0, sess_addr, 8'h01, 16'h000b, 1'b1, 8'h00, 2);
      send_frame(0);
      // fifteen option bytes, all-ones control and counter
      build_frame(MTYPE_UNCONF, 2'd0, sess_addr, 8'hff, 16'hffff, 1'b0, 8'h00, 0);
      send_frame(0);
      send_beat(FUNC_VERDICT, 8'h00, 1'b0, 1'b1);
      // longest frame allowed: largest payload, counter rollover
      build_frame(MTYPE_UNCONF, 2'd0, sess_addr, 8'h00, 16'h0001, 1'b1, 8'hff, 242);
      send_frame(0);
      send_beat(FUNC_VERDICT, 8'h00, 1'b0, 1'b1);
      // eleven bytes, then a lone byte
      build_frame(MTYPE_UNCONF, 2'd0, sess_addr, 8'h00, 16'h0002, 1'b0, 8'h00, 0);
      void'(frame_q.pop_back());
      send_frame(0);
      frame_q = '{8'h00};
      send_frame(0);
      // bad major version, bad message type
      build_frame(MTYPE_UNCONF, 2'd3, sess_addr, 8'h00, 16'h0002, 1'b0, 8'h00, 0);
      send_frame(0);
      build_frame(3'd7, 2'd0, sess_addr, 8'h00, 16'h0002, 1'b0, 8'h00, 0);
      send_frame(0);
      // wrong address on a confirmed frame still raises the ack
      build_frame(MTYPE_CONF, 2'd0, ~sess_addr, 8'h00, 16'h0002, 1'b0, 8'h00, 0);
      send_frame(0);
      send_beat(FUNC_UPLINK, 8'h00, 1'b0, 1'b0);
      // shorter than the options need
      build_frame(MTYPE_UNCONF, 2'd0, sess_addr, 8'h05, 16'h0002, 1'b0, 8'h00, 0);
      void'(frame_q.pop_back());
      void'(frame_q.pop_back());
      send_frame(0);
      // overlong frame, one byte past the limit
      build_frame(MTYPE_UNCONF, 2'd0, sess_addr, 8'h00, 16'h0002, 1'b1, 8'h01, 243);
      send_frame(0);
      // verdict and uplink beats slipped into a frame leave the capture alone
      build_frame(MTYPE_CONF, 2'd0, sess_addr, 8'h01, 16'h0005, 1'b1, 8'h10, 2);
      send_frame(40);
      send_beat(FUNC_VERDICT, 8'h00, 1'b0, 1'b1);

      // ---- random part, one session setting per phase ----
      phase_addr   = '{32'h0, 32'hffff_ffff, $urandom, $urandom, $urandom};
      phase_preset = '{32'h0, 32'hffff_ffff, $urandom, 32'h0000_fff8, 32'h1};
      for (int p = 0; p < N_PHASES; p++) begin
         // sender pauses until the block has nothing left to report
         drain_and_settle();
         write_session(phase_addr[p], phase_preset[p]);
         gaps_on = (p % 2 == 0);
         // the preset write dropped any waiting candidate
         send_beat(FUNC_VERDICT, 8'($urandom), 1'($urandom), 1'($urandom));
         if (p == 1) begin
            // receiver holds off while beats keep coming: pipe fills, input stalls
            holds_asked++;
            repeat (16)
               send_beat(($urandom_range(0, 1) == 1) ? FUNC_UPLINK : FUNC_VERDICT,
                         8'($urandom), 1'($urandom), 1'($urandom));
         end
         target = beats_sent + PHASE_BEATS;
         while (beats_sent < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
               send_random_frame(1'b0, 3);
               if ($urandom_range(0, 4) != 0)
                  send_beat(FUNC_VERDICT, 8'($urandom), 1'($urandom),
                            logic'($urandom_range(0, 7) != 0));
            end else if (sel < 75) begin
               send_random_frame(1'b1, 3);
            end else if (sel < 82) begin
               // noise of random length
               frame_q.delete();
               repeat ($urandom_range(1, 20)) frame_q.push_back(8'($urandom));
               send_frame(0);
            end else begin
               send_side_beat();
            end
         end
      end

      // everything owed must arrive, then nothing more may follow
      drain_and_settle();
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
